FILE: hdl/clb_pkg.sv
// Shared constants, types and the microcode table of the cursor list buffer.
`timescale 1ns / 1ps

package clb_pkg;

   // Default list depth
   localparam int CAPACITY_DEFAULT = 16;

   localparam int FUNC_W   = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;

   // Command codes
   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PEEK    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RETREAT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_END     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HEAD    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd5;

   // Microprogram step addresses
   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_FETCH    = 3'd0;
   localparam step_type STEP_DECODE   = 3'd1;
   localparam step_type STEP_SHIFT_RD = 3'd2;
   localparam step_type STEP_SHIFT_WR = 3'd3;
   localparam step_type STEP_DEL_FIX  = 3'd4;
   localparam step_type STEP_READ     = 3'd5;
   localparam step_type STEP_RESP     = 3'd6;

   // Datapath action of one step
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_DECIDE,
      ACT_SHIFT_RD,
      ACT_SHIFT_WR,
      ACT_DEL_FIX,
      ACT_READ,
      ACT_RESP
   } action_type;

   // Branch condition of one step
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_REQ_BEAT,
      COND_DEL_GO,
      COND_SHIFT_DONE,
      COND_RSP_FREE
   } cond_type;

   typedef struct packed {
      logic       req_ready;
      action_type action;
      cond_type   cond;
      step_type   target_true;
      step_type   target_false;
   } ctrl_word_type;

   // Control store: one word per step
   function automatic ctrl_word_type clb_ucode(input step_type step);
      ctrl_word_type w;
      w = '{1'b0, ACT_NONE, COND_ALWAYS, STEP_FETCH, STEP_FETCH};
      case (step)
         STEP_FETCH:    w = '{1'b1, ACT_NONE,     COND_REQ_BEAT,   STEP_DECODE,  STEP_FETCH};
         STEP_DECODE:   w = '{1'b0, ACT_DECIDE,   COND_DEL_GO,     STEP_SHIFT_RD, STEP_READ};
         STEP_SHIFT_RD: w = '{1'b0, ACT_SHIFT_RD, COND_SHIFT_DONE, STEP_DEL_FIX, STEP_SHIFT_WR};
         STEP_SHIFT_WR: w = '{1'b0, ACT_SHIFT_WR, COND_ALWAYS,     STEP_SHIFT_RD, STEP_SHIFT_RD};
         STEP_DEL_FIX:  w = '{1'b0, ACT_DEL_FIX,  COND_ALWAYS,     STEP_READ,    STEP_READ};
         STEP_READ:     w = '{1'b0, ACT_READ,     COND_ALWAYS,     STEP_RESP,    STEP_RESP};
         STEP_RESP:     w = '{1'b0, ACT_RESP,     COND_RSP_FREE,   STEP_FETCH,   STEP_RESP};
         default:       w = '{1'b0, ACT_NONE,     COND_ALWAYS,     STEP_FETCH,   STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

FILE: hdl/clb_if.sv
// Request and response channel interfaces of the cursor list buffer.
`timescale 1ns / 1ps

interface clb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [clb_pkg::FUNC_W-1:0]           func;
   logic signed [clb_pkg::DATA_W-1:0]    data_in;

   modport source (output valid, output func, output data_in, input ready);
   modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface clb_rsp_if #(
   parameter int CountWidth = 5
);
   logic                                 valid;
   logic                                 ready;
   logic [clb_pkg::STATUS_W-1:0]         status;
   logic signed [clb_pkg::DATA_W-1:0]    current_value;
   logic [CountWidth-1:0]                list_length;

   modport source (output valid, output status, output current_value,
                   output list_length, input ready);
   modport sink   (input valid, input status, input current_value,
                   input list_length, output ready);
endinterface

FILE: hdl/clb_store.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module clb_store #(
   parameter int    Depth     = clb_pkg::CAPACITY_DEFAULT,
   localparam int   AddrWidth = $clog2(Depth)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AddrWidth-1:0]          wr_addr,
   input  logic [clb_pkg::DATA_W-1:0]    wr_data,
   input  logic [AddrWidth-1:0]          rd_addr,
   output logic [clb_pkg::DATA_W-1:0]    rd_data
);

   logic [clb_pkg::DATA_W-1:0] mem [Depth];
   logic [clb_pkg::DATA_W-1:0] rd_data_ff;

   // Write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read word every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/cursor_list_buffer_core.sv
// Top level of the cursor list buffer: microcoded sequencer, state and result register.
`timescale 1ns / 1ps
//
// Bounded ordered list of signed 32-bit words with a cursor. Each request beat
// on req_if carries one command (append, peek, advance, retreat, delete) and
// a word used by append; each produces exactly one response beat on rsp_if
// with a status, the word at the cursor (zero when empty) and the list length.
// Both channels use valid/ready; a beat moves when both are high.
// A short microprogram steps the datapath: fetch, decode, read, respond;
// delete adds shift read, shift write and fix-up steps before the read.
// Append, peek, advance, retreat and unknown commands go from the request
// beat through decode and read to the respond step, which registers the
// response. Delete closes the gap behind the cursor one word at a time, a
// shift read and a shift write per entry behind the cursor, before fix-up.
// One item is in work at a time; req_if.ready is high only in the fetch
// step. The response register lets the next request be taken while a
// response waits; a stalled receiver holds the response and, once the next
// result is ready, the sequencer waits in its respond step.
// Synchronous reset empties the list, parks the cursor at the head and drops
// any pending response; store contents are left as they are.
module cursor_list_buffer_core #(
   parameter int  CAPACITY   = clb_pkg::CAPACITY_DEFAULT,
   localparam int IdxWidth   = $clog2(CAPACITY),
   localparam int CountWidth = $clog2(CAPACITY + 1)
) (
   input  logic        clock,
   input  logic        reset,
   clb_req_if.sink     req_if,
   clb_rsp_if.source   rsp_if
);

   // Sequencer
   clb_pkg::step_type      step_ff, step_in;
   clb_pkg::ctrl_word_type cw;
   logic                   cond_true;

   // List state
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [IdxWidth-1:0]    cursor_ff, cursor_in;
   logic [IdxWidth-1:0]    ptr_ff, ptr_in;
   logic [clb_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [clb_pkg::DATA_W-1:0]   word_ff, word_in;
   logic [clb_pkg::STATUS_W-1:0] status_ff, status_in;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [clb_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [clb_pkg::DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [CountWidth-1:0]         rsp_length_ff, rsp_length_in;

   // Store port
   logic                          st_wr_en;
   logic [IdxWidth-1:0]           st_wr_addr;
   logic [clb_pkg::DATA_W-1:0]    st_wr_data;
   logic [IdxWidth-1:0]           st_rd_addr;
   logic [clb_pkg::DATA_W-1:0]    st_rd_data;

   logic                          req_beat;
   logic                          rsp_free;
   logic [CountWidth-1:0]         cursor_next_wide;
   logic [CountWidth-1:0]         ptr_next_wide;

   assign cw       = clb_pkg::clb_ucode(step_ff);
   assign req_beat = req_if.valid && cw.req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   assign cursor_next_wide = CountWidth'(cursor_ff) + CountWidth'(1);
   assign ptr_next_wide    = CountWidth'(ptr_ff) + CountWidth'(1);

   // Pick the branch condition
   always_comb begin
      case (cw.cond)
         clb_pkg::COND_ALWAYS:     cond_true = 1'b1;
         clb_pkg::COND_REQ_BEAT:   cond_true = req_beat;
         clb_pkg::COND_DEL_GO:     cond_true = (func_ff == clb_pkg::FUNC_DELETE)
                                               && (count_ff != '0);
         clb_pkg::COND_SHIFT_DONE: cond_true = (ptr_next_wide >= count_ff);
         clb_pkg::COND_RSP_FREE:   cond_true = rsp_free;
         default:                  cond_true = 1'b1;
      endcase
   end

   assign step_in = cond_true ? cw.target_true : cw.target_false;

   // Datapath driven by the current control word
   always_comb begin
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      ptr_in        = ptr_ff;
      func_in       = func_ff;
      word_in       = word_ff;
      status_in     = status_ff;
      st_wr_en      = 1'b0;
      st_wr_addr    = ptr_ff;
      st_wr_data    = st_rd_data;
      st_rd_addr    = cursor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;

      // Latch the command on the request beat
      if (req_beat) begin
         func_in = req_if.func;
         word_in = req_if.data_in;
      end

      case (cw.action)
         clb_pkg::ACT_DECIDE: begin
            status_in = clb_pkg::ST_OK;
            case (func_ff)
               clb_pkg::FUNC_APPEND: begin
                  if (count_ff >= CountWidth'(CAPACITY)) begin
                     status_in = clb_pkg::ST_FULL;
                  end else begin
                     if (count_ff == '0) begin
                        cursor_in = '0;
                     end
                     st_wr_en   = 1'b1;
                     st_wr_addr = count_ff[IdxWidth-1:0];
                     st_wr_data = word_ff;
                     count_in   = count_ff + CountWidth'(1);
                  end
               end
               clb_pkg::FUNC_PEEK: begin
                  if (count_ff == '0) begin
                     status_in = clb_pkg::ST_EMPTY;
                  end
               end
               clb_pkg::FUNC_ADVANCE: begin
                  if (count_ff == '0) begin
                     status_in = clb_pkg::ST_EMPTY;
                  end else if (cursor_next_wide >= count_ff) begin
                     status_in = clb_pkg::ST_END;
                  end else begin
                     cursor_in = cursor_ff + IdxWidth'(1);
                  end
               end
               clb_pkg::FUNC_RETREAT: begin
                  if (count_ff == '0) begin
                     status_in = clb_pkg::ST_EMPTY;
                  end else if (cursor_ff == '0) begin
                     status_in = clb_pkg::ST_HEAD;
                  end else begin
                     cursor_in = cursor_ff - IdxWidth'(1);
                  end
               end
               clb_pkg::FUNC_DELETE: begin
                  if (count_ff == '0) begin
                     status_in = clb_pkg::ST_EMPTY;
                  end else begin
                     ptr_in = cursor_ff;
                  end
               end
               default: begin
                  status_in = clb_pkg::ST_UNKNOWN;
               end
            endcase
         end
         clb_pkg::ACT_SHIFT_RD: begin
            // Fetch the successor; the address wraps harmlessly on the last pass
            st_rd_addr = ptr_next_wide[IdxWidth-1:0];
         end
         clb_pkg::ACT_SHIFT_WR: begin
            // Move the successor down one place
            st_wr_en   = 1'b1;
            st_wr_addr = ptr_ff;
            st_wr_data = st_rd_data;
            ptr_in     = ptr_ff + IdxWidth'(1);
         end
         clb_pkg::ACT_DEL_FIX: begin
            count_in = count_ff - CountWidth'(1);
            if (cursor_ff != '0) begin
               cursor_in = cursor_ff - IdxWidth'(1);
            end
         end
         clb_pkg::ACT_READ: begin
            st_rd_addr = cursor_ff;
         end
         clb_pkg::ACT_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = (count_ff != '0) ? st_rd_data : '0;
               rsp_length_in = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= clb_pkg::STEP_FETCH;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      func_ff       <= func_in;
      word_ff       <= word_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
   end

   clb_store #(
      .Depth (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   assign req_if.ready         = cw.req_ready;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.current_value = rsp_value_ff;
   assign rsp_if.list_length   = rsp_length_ff;

`ifndef NO_ASSERTIONS
   // List never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(CAPACITY))
      else $error("list length beyond capacity");

   // Cursor sits inside a non-empty list and at the head of an empty one
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) ? (cursor_ff == '0)
                       : (CountWidth'(cursor_ff) < count_ff))
      else $error("cursor outside the list");

   // Shift writes only stay inside the held entries
   a_shift_inside: assert property (@(posedge clock) disable iff (reset)
      (step_ff == clb_pkg::STEP_SHIFT_WR) |-> (ptr_next_wide < count_ff))
      else $error("shift beyond the tail");

   // Length changes only in decode or delete fix-up
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(step_ff) == clb_pkg::STEP_DECODE ||
                              $past(step_ff) == clb_pkg::STEP_DEL_FIX))
      else $error("length changed outside decode or delete");

   // A new response is loaded only from the respond step
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(step_ff) == clb_pkg::STEP_RESP))
      else $error("response raised outside respond step");
`endif

endmodule
